>>> sv/lpc_pkg.sv
`default_nettype none

package lpc_pkg;

  localparam int DEF_SENSOR_COUNT = 8;
  localparam int DEF_SAMPLE_BITS  = 12;

  // normalized sensor value runs 0..SCALE_MAX
  localparam int SCALE_MAX = 1000;
  localparam int NORM_W    = 10;

  // position in 1/256 sensor pitch; doubled weights times 2^POS_FRAC
  localparam int POS_W     = 11;
  localparam int POS_MAX   = 1023;
  localparam int POS_MIN   = -1024;
  localparam int POS_FRAC  = 7;

  localparam int THR_W     = 13;
  localparam int THR_RESET = 200;

  localparam int FUNC_W       = 2;
  localparam int OUT_TDATA_W  = 16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_CAL   = 2'd1,
    FUNC_MEAS  = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_NWAIT,
    ST_ACC,
    ST_POS,
    ST_PWAIT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> sv/line_position_centroid.sv
// Line position from a row of reflectance sensors.
// Input channel in_*: in_tuser carries the operation (clear, calibrate, measure),
// in_tdata carries one frame of SENSOR_COUNT raw samples, sensor 0 in the low bits.
// Clear and calibrate complete in the accept cycle and give no output; the block
// is ready again on the next cycle. Measure gives one transaction on out_*:
// out_tdata holds the signed position, out_tuser the line-lost flag.
// A measure runs SENSOR_COUNT normalizing divisions and one centroid division on
// a single shared bit-serial divider of W bits (W = 23 with default parameters).
// Each normalizing division has a setup step before it and an accumulate step
// after it; a lost line skips the centroid division. in_tready stays low from
// the accept until the result has been moved into the output register.
// lost_threshold is written through cfg_we/cfg_wdata; the user writes it only
// while the block is idle, and the block itself does not enforce this.
// Reset (rst_n low, synchronous) empties the calibration ranges, clears the last
// position and the output valid flag and sets lost_threshold to 200.
// The result sits in an output register; if the receiver stalls, the block
// finishes the next measure and then waits until that register is taken.
`default_nettype none

module line_position_centroid import lpc_pkg::*; #(
  parameter int SENSOR_COUNT = DEF_SENSOR_COUNT,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // sample_0 .. sample_(SENSOR_COUNT-1), zero padded to bytes
  input  wire logic [((SENSOR_COUNT*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  // func
  input  wire logic [FUNC_W-1:0]      in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // position (signed), zero padded to 16 bits
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // line_lost
  output logic                        out_tuser,
  input  wire logic                   cfg_we,
  input  wire logic [THR_W-1:0]       cfg_wdata
);

  localparam int IDX_W   = $clog2(SENSOR_COUNT);
  localparam int WT_W    = IDX_W + 2;
  localparam int SUM_W   = $clog2(SCALE_MAX * SENSOR_COUNT + 1);
  localparam int WMAG_W  = $clog2(SCALE_MAX * SENSOR_COUNT * (SENSOR_COUNT - 1) + 1);
  localparam int WSUM_W  = WMAG_W + 1;
  localparam int NNUM_W  = SAMPLE_BITS + NORM_W;
  localparam int PNUM_W  = WMAG_W + POS_FRAC;
  localparam int DIV_NW  = (NNUM_W > PNUM_W) ? NNUM_W : PNUM_W;
  localparam int DIV_DW  = (SAMPLE_BITS > SUM_W) ? SAMPLE_BITS : SUM_W;
  localparam int HARD    = (1 << POS_FRAC) * (SENSOR_COUNT - 1);
  localparam int PQ_W    = $clog2(HARD + 1);
  localparam int QX_W    = ((PQ_W > POS_W) ? PQ_W : POS_W) + 1;
  localparam int CMP_W   = (SUM_W > THR_W) ? SUM_W : THR_W;
  localparam logic signed [POS_W-1:0] HARD_POS = POS_W'((HARD > POS_MAX) ? POS_MAX : HARD);
  localparam logic signed [POS_W-1:0] HARD_NEG = POS_W'((-HARD < POS_MIN) ? POS_MIN : -HARD);

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]        idx_r;
  logic [SAMPLE_BITS-1:0]  smp_r      [SENSOR_COUNT];
  logic [SAMPLE_BITS-1:0]  cal_low_r  [SENSOR_COUNT];
  logic [SAMPLE_BITS-1:0]  cal_high_r [SENSOR_COUNT];
  logic [SUM_W-1:0]        sum_r;
  logic signed [WSUM_W-1:0] wsum_r;
  logic [THR_W-1:0]        thr_r;
  logic signed [POS_W-1:0] last_pos_r;
  logic signed [POS_W-1:0] res_pos_r;
  logic                    res_lost_r;
  logic                    out_valid_r;
  logic signed [POS_W-1:0] out_pos_r;
  logic                    out_lost_r;

  logic                    in_acc;
  logic                    out_load;
  logic                    div_start;
  logic [DIV_NW-1:0]       div_num;
  logic [DIV_DW-1:0]       div_den;
  logic                    div_done;
  logic [DIV_NW-1:0]       div_quo;

  // normalization of the current sensor
  logic [SAMPLE_BITS-1:0]  lo, hi, smp, clamped, diff;
  logic                    empty;
  logic [NNUM_W-1:0]       norm_num;
  logic [SAMPLE_BITS-1:0]  norm_den;

  // accumulation
  logic [NORM_W-1:0]             q_norm;
  logic signed [WT_W-1:0]        wt;
  logic signed [NORM_W+WT_W:0]   prod;

  // centroid
  logic                    lost;
  logic                    wneg;
  logic [WSUM_W-1:0]       wabs;
  logic [PNUM_W-1:0]       pos_num;
  logic [QX_W-1:0]         qx;
  logic signed [POS_W-1:0] pos_sat;

  assign in_acc = in_tvalid && in_tready;

  assign lo      = cal_low_r[idx_r];
  assign hi      = cal_high_r[idx_r];
  assign smp     = smp_r[idx_r];
  assign empty   = hi <= lo;
  assign clamped = (smp < lo) ? lo : ((smp > hi) ? hi : smp);
  assign diff    = clamped - lo;
  assign norm_num = empty ? '0 : NNUM_W'(diff) * NNUM_W'(SCALE_MAX);
  assign norm_den = empty ? SAMPLE_BITS'(1) : hi - lo;

  assign q_norm = div_quo[NORM_W-1:0];
  assign wt     = $signed({1'b0, idx_r, 1'b0}) - $signed(WT_W'(SENSOR_COUNT - 1));
  assign prod   = $signed({1'b0, q_norm}) * wt;

  assign lost    = (sum_r == '0) || (CMP_W'(sum_r) < CMP_W'(thr_r));
  assign wneg    = wsum_r[WSUM_W-1];
  assign wabs    = wneg ? -wsum_r : wsum_r;
  assign pos_num = {wabs[WMAG_W-1:0], {POS_FRAC{1'b0}}};

  assign qx = QX_W'(div_quo[PQ_W-1:0]);
  always_comb begin
    if (wneg) begin
      pos_sat = (qx > QX_W'(-POS_MIN)) ? POS_W'(POS_MIN) : -POS_W'(qx);
    end else begin
      pos_sat = (qx > QX_W'(POS_MAX)) ? POS_W'(POS_MAX) : POS_W'(qx);
    end
  end

  lpc_div #(
    .NUM_W (DIV_NW),
    .DEN_W (DIV_DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == FUNC_MEAS)) state_nxt = ST_NORM;
      end
      ST_NORM:  state_nxt = ST_NWAIT;
      ST_NWAIT: begin
        if (div_done) state_nxt = ST_ACC;
      end
      ST_ACC: begin
        state_nxt = (idx_r == IDX_W'(SENSOR_COUNT - 1)) ? ST_POS : ST_NORM;
      end
      ST_POS:   state_nxt = lost ? ST_DONE : ST_PWAIT;
      ST_PWAIT: begin
        if (div_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    div_num   = DIV_NW'(norm_num);
    div_den   = DIV_DW'(norm_den);
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_NORM: div_start = 1'b1;
      ST_POS: begin
        div_start = !lost;
        div_num   = DIV_NW'(pos_num);
        div_den   = DIV_DW'(sum_r);
      end
      default: ;
    endcase
  end

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= THR_W'(THR_RESET);
      last_pos_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        cal_low_r[i]  <= '1;
        cal_high_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) thr_r <= cfg_wdata;

      if (in_acc) begin
        for (int i = 0; i < SENSOR_COUNT; i++) begin
          smp_r[i] <= in_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
        end
        case (in_tuser)
          FUNC_CLEAR: begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
              cal_low_r[i]  <= '1;
              cal_high_r[i] <= '0;
            end
          end
          FUNC_CAL: begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
              if (in_tdata[i*SAMPLE_BITS +: SAMPLE_BITS] < cal_low_r[i])
                cal_low_r[i] <= in_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
              if (in_tdata[i*SAMPLE_BITS +: SAMPLE_BITS] > cal_high_r[i])
                cal_high_r[i] <= in_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
            end
          end
          FUNC_MEAS: begin
            idx_r  <= '0;
            sum_r  <= '0;
            wsum_r <= '0;
          end
          default: ;  // unused code, ignored
        endcase
      end

      case (state_r)
        ST_ACC: begin
          sum_r  <= sum_r + SUM_W'(q_norm);
          wsum_r <= wsum_r + WSUM_W'(prod);
          idx_r  <= idx_r + 1'b1;
        end
        ST_POS: begin
          if (lost) begin
            // steer hard toward the side the line was last seen
            res_pos_r  <= (last_pos_r > 0) ? HARD_POS : HARD_NEG;
            res_lost_r <= 1'b1;
          end
        end
        ST_PWAIT: begin
          if (div_done) begin
            res_pos_r  <= pos_sat;
            res_lost_r <= 1'b0;
            last_pos_r <= pos_sat;
          end
        end
        default: ;
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
        out_pos_r   <= res_pos_r;
        out_lost_r  <= res_lost_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_pos_r[POS_W-1:0]);
  assign out_tuser  = out_lost_r;

endmodule

`default_nettype wire

>>> sv/lpc_div.sv
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module lpc_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 13
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quo
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] nq_r;   // numerator shifts out at the top, quotient in at the bottom

  logic [DEN_W:0] rem_sh;
  logic [DEN_W:0] trial;
  logic           fits;

  assign rem_sh = {rem_r, nq_r[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};
  assign trial  = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W - 1);
        rem_r  <= '0;
        den_r  <= den;
        nq_r   <= num;
      end else if (busy_r) begin
        rem_r <= fits ? trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        nq_r  <= {nq_r[NUM_W-2:0], fits};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = nq_r;

endmodule

`default_nettype wire

>>> sv/lpc_chk.sv
`default_nettype none

module lpc_chk import lpc_pkg::*; #(
  parameter int SENSOR_COUNT = DEF_SENSOR_COUNT
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic [FUNC_W-1:0]      in_tuser,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tuser
);

  localparam int HARD = (1 << POS_FRAC) * (SENSOR_COUNT - 1);
  localparam logic [POS_W-1:0] HARD_POS = POS_W'((HARD > POS_MAX) ? POS_MAX : HARD);
  localparam logic [POS_W-1:0] HARD_NEG = POS_W'((-HARD < POS_MIN) ? POS_MIN : -HARD);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output transaction changed while stalled");

  // clear and calibrate finish in the accept cycle
  a_fast_ops: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != FUNC_MEAS) |=> in_tready)
    else $error("block busy after clear or calibrate");

  // a measure occupies the block
  a_meas_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FUNC_MEAS) |=> !in_tready)
    else $error("block ready right after accepting a measure");

  // a lost line always reports the hard-steer position
  a_lost_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (out_tdata[POS_W-1:0] == HARD_POS) || (out_tdata[POS_W-1:0] == HARD_NEG))
    else $error("line lost with a position other than hard left or right");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not idle after reset");

endmodule

bind line_position_centroid lpc_chk #(
  .SENSOR_COUNT (SENSOR_COUNT)
) u_lpc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

>>> dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lpc_pkg::*;

  localparam int NS = DEF_SENSOR_COUNT;
  localparam int SW = DEF_SAMPLE_BITS;
  localparam int HARD = 128 * (NS - 1);
  localparam logic [POS_W-1:0] HARD_LEFT  = POS_W'(-HARD);
  localparam logic [POS_W-1:0] HARD_RIGHT = POS_W'(HARD);
  localparam logic [POS_W-1:0] NO_POS     = '0;
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 260;
  localparam int PHASES        = 8;
  localparam int ITEMS_TOTAL   = 1650;

  typedef logic [NS-1:0][SW-1:0] frame_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             lost;
  } track_t;

  typedef struct packed {
    logic [FUNC_W-1:0] op;
    frame_t            smp;
    logic              typed;
    logic [POS_W-1:0]  pos;
    logic              lost;
  } plan_row_t;

  typedef enum int {SHAPE_NOISE, SHAPE_LINE, SHAPE_DARK, SHAPE_EXTREME, SHAPE_BRIGHT} shape_t;

  localparam int PLAN_LEN = 25;
  // typed positions hold only where the answer is plain (empty ranges, lone sensor, flat, all dark)
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{FUNC_MEAS,  {NS{12'h000}}, 1'b1, HARD_LEFT, 1'b1},
    '{FUNC_MEAS,  {NS{12'hFFF}}, 1'b1, HARD_LEFT, 1'b1},
    '{FUNC_SPARE, {NS{12'hA5A}}, 1'b0, NO_POS, 1'b0},
    '{FUNC_CAL,   {NS{12'h000}}, 1'b0, NO_POS, 1'b0},
    '{FUNC_CAL,   {NS{12'hFFF}}, 1'b0, NO_POS, 1'b0},
    '{FUNC_MEAS,  {NS{12'hFFF}}, 1'b1, NO_POS, 1'b0},
    '{FUNC_MEAS,  {{7{12'h000}}, 12'hFFF}, 1'b1, HARD_LEFT, 1'b0},
    '{FUNC_MEAS,  {12'hFFF, {7{12'h000}}}, 1'b1, HARD_RIGHT, 1'b0},
    '{FUNC_MEAS,  {NS{12'h000}}, 1'b1, HARD_RIGHT, 1'b1},
    '{FUNC_MEAS,  {4{12'h555, 12'hAAA}}, 1'b0, NO_POS, 1'b0},
    '{FUNC_MEAS,  {4{12'hAAA, 12'h555}}, 1'b0, NO_POS, 1'b0},
    '{FUNC_MEAS,  {{3{12'h000}}, 12'h800, 12'h800, {3{12'h000}}}, 1'b0, NO_POS, 1'b0},
    '{FUNC_MEAS,  {{6{12'h000}}, 12'h001, 12'h000}, 1'b0, NO_POS, 1'b0},
    '{FUNC_SPARE, {NS{12'hFFF}}, 1'b0, NO_POS, 1'b0},
    '{FUNC_CLEAR, {NS{12'h5A5}}, 1'b0, NO_POS, 1'b0},
    '{FUNC_MEAS,  {NS{12'hFFF}}, 1'b0, NO_POS, 1'b0},
    '{FUNC_CAL,   {NS{12'h100}}, 1'b0, NO_POS, 1'b0},
    '{FUNC_MEAS,  {NS{12'hFFF}}, 1'b0, NO_POS, 1'b0},
    '{FUNC_CAL,   {12'h100, {7{12'hC00}}}, 1'b0, NO_POS, 1'b0},
    '{FUNC_MEAS,  {NS{12'hFFF}}, 1'b0, NO_POS, 1'b0},
    '{FUNC_MEAS,  {NS{12'h000}}, 1'b0, NO_POS, 1'b0},
    '{FUNC_CAL,   {NS{12'h000}}, 1'b0, NO_POS, 1'b0},
    '{FUNC_MEAS,  {12'h040, 12'h080, 12'h100, 12'h200, 12'h400, 12'h7FF, 12'h3FF, 12'h000},
                  1'b0, NO_POS, 1'b0},
    '{FUNC_MEAS,  {12'h000, 12'h0C0, {6{12'h000}}}, 1'b0, NO_POS, 1'b0},
    '{FUNC_CLEAR, {NS{12'h000}}, 1'b0, NO_POS, 1'b0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [NS*SW-1:0]       in_tdata = '0;   // sample_0 .. sample_7
  logic [FUNC_W-1:0]      in_tuser = FUNC_CLEAR;   // func
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;   // position, zero padded
  logic                   out_tuser;   // line_lost
  logic                   cfg_we = 1'b0;
  logic [THR_W-1:0]       cfg_wdata = '0;

  // predictor state
  logic [SW-1:0] cal_floor [NS];
  logic [SW-1:0] cal_ceiling [NS];
  int            last_pos;
  int            lost_thr;

  track_t pending_positions [$];
  track_t want;
  int     burst_left = 0;
  int     stall_left = 0;
  bit     rx_steady = 1'b0;
  int     mismatch_count = 0;
  int     results_checked = 0;
  int     lost_seen = 0;
  int     frames_sent = 0;
  int     thr_plan [PHASES] = '{THR_RESET, 0, 8000, 1, -1, 4000, -1, THR_RESET};

  line_position_centroid uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic void flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH at %0t ns: %s", $time, msg);
  endfunction

  function automatic bit predict_line_frame(input logic [FUNC_W-1:0] op, input frame_t f,
                                            output logic [POS_W-1:0] pos, output logic lost);
    int     lo, hi, s, norm;
    longint sum, wsum, q;
    pos = '0;
    lost = 1'b0;
    sum = 0;
    wsum = 0;
    case (op)
      FUNC_CLEAR: begin
        for (int i = 0; i < NS; i++) begin
          cal_floor[i] = '1;
          cal_ceiling[i] = '0;
        end
        return 1'b0;
      end
      FUNC_CAL: begin
        for (int i = 0; i < NS; i++) begin
          if (f[i] < cal_floor[i]) cal_floor[i] = f[i];
          if (f[i] > cal_ceiling[i]) cal_ceiling[i] = f[i];
        end
        return 1'b0;
      end
      FUNC_MEAS: begin
        for (int i = 0; i < NS; i++) begin
          lo = cal_floor[i];
          hi = cal_ceiling[i];
          s = f[i];
          norm = 0;
          // empty range reads as zero
          if (hi > lo) begin
            if (s < lo) s = lo;
            if (s > hi) s = hi;
            norm = (s - lo) * SCALE_MAX / (hi - lo);
          end
          sum += norm;
          wsum += longint'(norm) * (2 * i - (NS - 1));
        end
        lost = (sum == 0) || (sum < lost_thr);
        if (lost) begin
          q = (last_pos > 0) ? HARD : -HARD;
        end else begin
          q = wsum * 128 / sum;   // truncates toward zero
          if (q > POS_MAX) q = POS_MAX;
          if (q < POS_MIN) q = POS_MIN;
          last_pos = int'(q);
        end
        pos = q[POS_W-1:0];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic frame_t rand_frame(input shape_t shape);
    frame_t f;
    int     centre, amp, floor_lvl, d;
    centre = $urandom_range(0, NS - 1);
    amp = $urandom_range(1500, 4095);
    floor_lvl = $urandom_range(0, 600);
    for (int i = 0; i < NS; i++) begin
      d = (i > centre) ? i - centre : centre - i;
      case (shape)
        SHAPE_LINE: begin
          if (d == 0) f[i] = SW'(amp);
          else if (d == 1) f[i] = SW'($urandom_range(floor_lvl, amp));
          else f[i] = SW'(floor_lvl + $urandom_range(0, 200));
        end
        SHAPE_DARK:    f[i] = SW'($urandom_range(0, 350));
        SHAPE_EXTREME: f[i] = $urandom_range(0, 1) ? '1 : '0;
        SHAPE_BRIGHT:  f[i] = SW'($urandom_range(3500, 4095));
        default:       f[i] = SW'($urandom_range(0, 4095));
      endcase
    end
    return f;
  endfunction

  task automatic send_frame(input logic [FUNC_W-1:0] op, input frame_t f, input logic typed,
                            input logic [POS_W-1:0] typed_pos, input logic typed_lost);
    int               gap;
    logic [POS_W-1:0] p;
    logic             l;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 260) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= f;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    frames_sent++;
    if (predict_line_frame(op, f, p, l)) begin
      if (typed) pending_positions.push_back('{typed_pos, typed_lost});
      else pending_positions.push_back('{p, l});
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_positions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input int v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= THR_W'(v);
    @(negedge clk);
    cfg_we <= 1'b0;
    lost_thr = v;
  endtask

  // mostly clear / calibrate sweep / measure runs, with some stray and unused operations
  task automatic run_phase(input int budget);
    int made, n_cal, n_meas, roll;
    made = 0;
    while (made < budget) begin
      roll = $urandom_range(0, 19);
      if (roll == 0) begin
        send_frame(FUNC_SPARE, rand_frame(SHAPE_NOISE), 1'b0, NO_POS, 1'b0);
      end else if (roll < 3) begin
        send_frame(FUNC_W'($urandom_range(0, 2)), rand_frame(shape_t'($urandom_range(0, 4))),
                   1'b0, NO_POS, 1'b0);
        made++;
      end else begin
        if ($urandom_range(0, 1)) begin
          send_frame(FUNC_CLEAR, rand_frame(SHAPE_NOISE), 1'b0, NO_POS, 1'b0);
          made++;
        end
        n_cal = $urandom_range(1, 8);
        n_meas = $urandom_range(3, 25);
        repeat (n_cal) begin
          send_frame(FUNC_CAL, rand_frame(shape_t'($urandom_range(0, 4))), 1'b0, NO_POS, 1'b0);
          made++;
        end
        repeat (n_meas) begin
          roll = $urandom_range(0, 9);
          send_frame(FUNC_MEAS,
                     rand_frame(roll < 5 ? SHAPE_LINE : shape_t'($urandom_range(0, 4))),
                     1'b0, NO_POS, 1'b0);
          made++;
        end
      end
    end
  endtask

  // receiver: short stalls often, a long one now and then, none started while rx_steady is set
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (!rx_steady) begin
        if ($urandom_range(0, 99) < 1) stall_left <= $urandom_range(250, 400);
        else if ($urandom_range(0, 99) < 15) stall_left <= $urandom_range(1, 12);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_positions.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: tdata %h tuser %b",
                                out_tdata, out_tuser));
      end else begin
        want = pending_positions.pop_front();
        results_checked++;
        if (want.lost) lost_seen++;
        if (out_tdata !== {{(OUT_TDATA_W-POS_W){1'b0}}, want.pos} || out_tuser !== want.lost)
          flag_mismatch($sformatf("exp position %0d lost %b, got position %0d lost %b (tdata %h)",
                                  $signed(want.pos), want.lost,
                                  $signed(out_tdata[POS_W-1:0]), out_tuser, out_tdata));
      end
    end
  end

  initial begin
    #25_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    for (int i = 0; i < NS; i++) begin
      cal_floor[i] = '1;
      cal_ceiling[i] = '0;
    end
    last_pos = 0;
    lost_thr = THR_RESET;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < PLAN_LEN; r++)
      send_frame(PLAN[r].op, PLAN[r].smp, PLAN[r].typed, PLAN[r].pos, PLAN[r].lost);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      rx_steady = (ph == 2 || ph == 5);
      if (ph > 0) write_threshold(thr_plan[ph] < 0 ? $urandom_range(0, 8000) : thr_plan[ph]);
      run_phase((ITEMS_TOTAL - PLAN_LEN) / PHASES);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Drove %0d frames over %0d threshold settings, min and max included.",
             frames_sent, PHASES);
    $display("Checked %0d positions, %0d of them line-lost; %0d mismatches.",
             results_checked, lost_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/lpc_pkg.sv
sv/lpc_div.sv
sv/line_position_centroid.sv
sv/lpc_chk.sv
dv/tb.sv
